// ===== rtl/lrm_pkg.sv =====
// ----------------------------------------------------------------------------
// lrm_pkg
// Shared types and constants for the linear recurrence matrix power block.
// ----------------------------------------------------------------------------
package lrm_pkg;

    localparam int unsigned IDX_W = 31;
    localparam int unsigned VAL_W = 30;
    localparam logic [VAL_W-1:0] MODULUS = 30'd1000000007;
    localparam logic [IDX_W-1:0] SEED_TERMS = 31'd3;

    typedef enum logic [4:0] {
        OP_NONE    = 5'b00001,
        OP_LOAD    = 5'b00010,
        OP_MAC     = 5'b00100,
        OP_WR_VEC  = 5'b01000,
        OP_WR_MAT  = 5'b10000
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] row;
        logic [1:0] col;
        logic [1:0] k;
        logic       vec_sel;
        logic       acc_clr;
        logic       commit;
    } t_cmd;

    typedef struct packed {
        logic busy;
    } t_status;

endpackage

// ===== rtl/lrm_if.sv =====
// ----------------------------------------------------------------------------
// lrm_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface lrm_if #(
    parameter int unsigned W = 31
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/lrm_mulmod.sv =====
// ----------------------------------------------------------------------------
// lrm_mulmod
// Multicycle modular multiply: shift-add, two product bits per cycle.
// ----------------------------------------------------------------------------
module lrm_mulmod (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lrm_pkg::VAL_W-1:0]     i_a,
    input  logic [lrm_pkg::VAL_W-1:0]     i_b,
    output logic                          o_done,
    output logic [lrm_pkg::VAL_W-1:0]     o_p
);
    localparam int unsigned W = lrm_pkg::VAL_W;

    logic [W-1:0] r_acc, n_acc;
    logic [W-1:0] r_a;
    logic [W-1:0] r_b;
    logic [4:0]   r_cnt;
    logic         r_run;

    function automatic logic [W-1:0] step(input logic [W-1:0] acc,
                                          input logic bit_b,
                                          input logic [W-1:0] a);
        logic [W:0] d;
        logic [W:0] s;
        d = {acc, 1'b0};
        if (d >= {1'b0, lrm_pkg::MODULUS}) d = d - {1'b0, lrm_pkg::MODULUS};
        s = d + (bit_b ? {1'b0, a} : '0);
        if (s >= {1'b0, lrm_pkg::MODULUS}) s = s - {1'b0, lrm_pkg::MODULUS};
        return s[W-1:0];
    endfunction

    always_comb begin
        n_acc = step(step(r_acc, r_b[W-1], r_a), r_b[W-2], r_a);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_run <= 1'b1;
            r_cnt <= '0;
            r_acc <= '0;
            r_a   <= (i_a >= lrm_pkg::MODULUS) ? i_a - lrm_pkg::MODULUS : i_a;
            r_b   <= i_b;
        end else if (r_run) begin
            r_acc <= n_acc;
            r_b   <= {r_b[W-3:0], 2'b00};
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'(W/2 - 1)) r_run <= 1'b0;
        end
    end

    assign o_done = r_run && (r_cnt == 5'(W/2 - 1));
    assign o_p    = n_acc;
endmodule

// ===== rtl/lrm_datapath.sv =====
// ----------------------------------------------------------------------------
// lrm_datapath
// Vector, base matrix and product registers around one modular multiplier.
// ----------------------------------------------------------------------------
module lrm_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lrm_pkg::t_cmd              i_cmd,
    input  logic                       i_mul_start,
    output logic                       o_mul_done,
    output logic [lrm_pkg::VAL_W-1:0]  o_result
);
    localparam int unsigned W = lrm_pkg::VAL_W;

    logic [W-1:0] r_vec [3];
    logic [W-1:0] r_base [3][3];
    logic [W-1:0] r_tv [3];
    logic [W-1:0] r_tm [3][3];
    logic [W-1:0] r_acc;
    logic [W-1:0] mul_a, mul_b, mul_p;
    logic [W:0]   sum;
    logic         mul_done;

    always_comb begin
        mul_b = r_base[i_cmd.k][i_cmd.col];
        mul_a = i_cmd.vec_sel ? r_vec[i_cmd.k] : r_base[i_cmd.row][i_cmd.k];
        sum   = {1'b0, r_acc} + {1'b0, mul_p};
        if (sum >= {1'b0, lrm_pkg::MODULUS}) sum = sum - {1'b0, lrm_pkg::MODULUS};
    end

    lrm_mulmod u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            lrm_pkg::OP_LOAD: begin
                // companion matrix: ones at (0,0), (0,2), (1,0), (2,1)
                for (int i = 0; i < 3; i++) begin
                    r_vec[i] <= W'(1);
                    for (int j = 0; j < 3; j++) begin
                        r_base[i][j] <= ((i == 0 && j != 1) || (i == j + 1)) ? W'(1) : '0;
                    end
                end
                r_acc <= '0;
            end
            lrm_pkg::OP_MAC: begin
                if (i_cmd.acc_clr) r_acc <= '0;
                else if (mul_done) begin
                    r_acc <= sum[W-1:0];
                    if (i_cmd.commit) begin
                        if (i_cmd.vec_sel) r_tv[i_cmd.col] <= sum[W-1:0];
                        else r_tm[i_cmd.row][i_cmd.col] <= sum[W-1:0];
                    end
                end
            end
            lrm_pkg::OP_WR_VEC: begin
                for (int i = 0; i < 3; i++) r_vec[i] <= r_tv[i];
            end
            lrm_pkg::OP_WR_MAT: begin
                r_base <= r_tm;
            end
            default: begin
            end
        endcase
    end

    assign o_mul_done = mul_done;
    assign o_result   = r_vec[0];
endmodule

// ===== rtl/lrm_ctrl.sv =====
// ----------------------------------------------------------------------------
// lrm_ctrl
// Sequencer for square-and-multiply over the exponent bits.
// ----------------------------------------------------------------------------
module lrm_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [lrm_pkg::IDX_W-1:0]  i_index,
    output logic                       o_in_ready,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output lrm_pkg::t_cmd              o_cmd,
    output logic                       o_mul_start,
    input  logic                       i_mul_done
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_START = 6'b000100,
        S_WAIT  = 6'b001000,
        S_WRITE = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [lrm_pkg::IDX_W-1:0] r_e;
    logic r_vec_pass;
    logic [1:0] r_row, r_col, r_k;

    always_comb begin
        o_cmd = '{op: lrm_pkg::OP_NONE, row: r_row, col: r_col, k: r_k,
                  vec_sel: r_vec_pass, acc_clr: 1'b0, commit: (r_k == 2'd2)};
        o_mul_start = 1'b0;
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) begin
                o_cmd.op = lrm_pkg::OP_LOAD;
                n_state  = S_CHECK;
            end
            S_CHECK: n_state = (r_e == '0) ? S_DONE : S_START;
            S_START: begin
                o_cmd.op = lrm_pkg::OP_MAC;
                o_cmd.acc_clr = (r_k == 2'd0);
                o_mul_start = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                o_cmd.op = lrm_pkg::OP_MAC;
                if (i_mul_done) begin
                    if (r_k != 2'd2) n_state = S_START;
                    else if (r_col != 2'd2) n_state = S_START;
                    else if (!r_vec_pass && r_row != 2'd2) n_state = S_START;
                    else n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.op = r_vec_pass ? lrm_pkg::OP_WR_VEC : lrm_pkg::OP_WR_MAT;
                n_state = r_vec_pass ? S_START : S_CHECK;
            end
            S_DONE: if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        case (r_state)
            S_IDLE: begin
                r_e <= (i_index > lrm_pkg::SEED_TERMS) ? i_index - lrm_pkg::SEED_TERMS : '0;
                r_row <= '0; r_col <= '0; r_k <= '0;
            end
            S_CHECK: begin
                r_vec_pass <= r_e[0];
                r_row <= '0; r_col <= '0; r_k <= '0;
            end
            S_WAIT: if (i_mul_done) begin
                if (r_k != 2'd2) r_k <= r_k + 2'd1;
                else begin
                    r_k <= '0;
                    if (r_col != 2'd2) r_col <= r_col + 2'd1;
                    else begin
                        r_col <= '0;
                        if (!r_vec_pass && r_row != 2'd2) r_row <= r_row + 2'd1;
                        else r_row <= '0;
                    end
                end
            end
            S_WRITE: begin
                if (r_vec_pass) r_vec_pass <= 1'b0;
                else r_e <= r_e >> 1;
            end
            default: begin
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_DONE);

    a_start_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_CHECK))
        else $error("item not taken");
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !i_out_ready) |=> (r_state == S_DONE))
        else $error("result dropped");
    a_mul_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_mul_done |-> (r_state == S_WAIT))
        else $error("stray multiply done");
endmodule

// ===== rtl/linear_recurrence_matrix_power_mod.sv =====
// Sequence: for n <= 3 the result goes valid after a check; each bit of
// n-3 adds 27 multiplies, write and check; 9 more multiplies and a write when set.
// Flow: one item at a time; next index taken the cycle after the result leaves.
// Reset: synchronous active low, idles empty.
// ----------------------------------------------------------------------------
// linear_recurrence_matrix_power_mod
// Term n mod 1000000007 of a(n)=a(n-1)+a(n-3) by matrix exponentiation.
// ----------------------------------------------------------------------------
module linear_recurrence_matrix_power_mod (
    input  logic i_clk,
    input  logic i_rst_n,
    lrm_if.sink   i_in,
    lrm_if.source o_out
);
    lrm_pkg::t_cmd cmd;
    logic mul_start, mul_done;

    lrm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_index     (i_in.data),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .o_mul_start (mul_start),
        .i_mul_done  (mul_done)
    );

    lrm_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_mul_start (mul_start),
        .o_mul_done  (mul_done),
        .o_result    (o_out.data)
    );
endmodule
